// ===== rtl/bdsr_pkg.sv =====
// Shared types and constants for the bounded deque with search and remove.
package bdsr_pkg;

  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int LEN_W       = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_REMOVE     = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_DATA,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] popped;
    logic              found;
  } res_t;

endpackage

// ===== rtl/bdsr_store.sv =====
// Entry store: single write port and one registered read port.
module bdsr_store #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [bdsr_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [bdsr_pkg::DATA_W-1:0] rd_data
);
  import bdsr_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bounded_deque_search_remove.sv =====
// Top level of the bounded deque with search and remove-first-match.
//
// The block keeps an ordered list of up to DEPTH 32-bit values in a circular
// store with one write and one read port and takes one command item at a
// time: push front, push back, pop front, pop back, search, or remove the
// first match (counted from the front). Every item returns exactly one
// result item carrying status, popped value, found flag and the length after
// the command. A small sequencer drives one slot adder (front index plus
// position, wrapped at DEPTH), the store's single read port and one 32-bit
// comparator, so each entry visited takes a state that issues the read and
// a state that uses the registered data. A search examines at most length
// entries, and a remove scans for the first match and then moves every later
// entry one place forward. The input is ready only while the sequencer is
// idle; a finished result sits in an output register, so the next item can
// be accepted while it waits. The store needs no clearing after reset,
// because only entries inside the list are ever read.
module bounded_deque_search_remove #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: command[2:0], value[34:3], zero padding[39:35].
  input  logic [bdsr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: status[1:0], popped_value[33:2], found[34],
  // length[39:35].
  output logic [bdsr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bdsr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;

  // Sequencer and list state.
  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  res_t              res_r, res_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Store port.
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [DATA_W-1:0] rd_data;

  // Shared slot adder: position from the front to physical slot.
  logic [CW-1:0] slot_pos;
  logic [CW:0]   slot_sum;
  logic [CW:0]   slot_wrap;
  logic [AW-1:0] slot_idx;

  logic          in_fire;
  logic          full;
  logic          empty;
  logic          match;
  logic          out_free;
  logic [CW-1:0] pos_inc;
  logic          more_after;
  logic          shift_more;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [LW-1:0] len_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign full       = (count_r == CW'(DEPTH));
  assign empty      = (count_r == '0);
  assign match      = (rd_data == value_r);
  assign pos_inc    = pos_r + CW'(1);
  assign more_after = (pos_inc < count_r);
  // Another entry still has to move when pos + 2 is inside the list.
  assign shift_more = (({1'b0, pos_r} + (CW+1)'(2)) < {1'b0, count_r});

  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // Operand of the slot adder for each step of the sequence.
  always_comb begin
    slot_pos = pos_r;
    case (state_r)
      S_EXEC: begin
        if (cmd_r == CMD_PUSH_BACK) begin
          slot_pos = count_r;
        end else if (cmd_r == CMD_POP_BACK) begin
          slot_pos = count_r - CW'(1);
        end else begin
          slot_pos = '0;
        end
      end
      S_SHIFT_RD: slot_pos = pos_inc;
      default:    slot_pos = pos_r;
    endcase
  end

  // Whenever the slot is used both operands are below DEPTH, so one compare
  // and subtract wraps the sum.
  assign slot_sum  = (CW+1)'(head_r) + (CW+1)'(slot_pos);
  assign slot_wrap = (slot_sum >= (CW+1)'(DEPTH)) ? slot_sum - (CW+1)'(DEPTH) : slot_sum;
  assign slot_idx  = slot_wrap[AW-1:0];

  assign len_ext = LW'(count_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_POP_FRONT, CMD_POP_BACK: state_nxt = empty ? S_DONE : S_POP_DATA;
          CMD_SEARCH, CMD_REMOVE:      state_nxt = empty ? S_DONE : S_SCAN_RD;
          default:                     state_nxt = S_DONE;
        endcase
      end
      S_POP_DATA: state_nxt = S_DONE;
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (match) begin
          state_nxt = (cmd_r == CMD_REMOVE && more_after) ? S_SHIFT_RD : S_DONE;
        end else begin
          state_nxt = more_after ? S_SCAN_RD : S_DONE;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = shift_more ? S_SHIFT_RD : S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store controls.
  always_comb begin
    cmd_nxt       = cmd_r;
    value_nxt     = value_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = slot_idx;
    wr_data       = value_r;
    rd_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = cmd_t'(in_tdata[CMD_W-1:0]);
          value_nxt = in_tdata[CMD_W +: DATA_W];
          pos_nxt   = '0;
          res_nxt   = '{status: ST_OK, popped: '0, found: 1'b0};
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_PUSH_FRONT: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = head_dec;
              head_nxt  = head_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_PUSH_BACK: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (empty) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              head_nxt  = head_inc;
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              rd_en     = 1'b1;
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_SEARCH, CMD_REMOVE: begin
            if (empty) begin
              res_nxt.status = ST_MISS;
            end
          end
          default: begin
            // Unused command codes leave the list alone and report ok.
          end
        endcase
      end
      S_POP_DATA: res_nxt.popped = rd_data;
      S_SCAN_RD:  rd_en = 1'b1;
      S_SCAN_CMP: begin
        if (match) begin
          res_nxt.found = 1'b1;
          // A match at the back needs no entries moved.
          if (cmd_r == CMD_REMOVE && !more_after) begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          pos_nxt = pos_inc;
          if (!more_after) begin
            res_nxt.status = ST_MISS;
          end
        end
      end
      S_SHIFT_RD: rd_en = 1'b1;
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        pos_nxt = pos_inc;
        if (!shift_more) begin
          count_nxt = count_r - CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {len_ext[LEN_W-1:0], res_r.found, res_r.popped, res_r.status};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    value_r    <= value_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  bdsr_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot_idx),
    .rd_data (rd_data)
  );

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // The front index always names a real slot.
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("front index out of range");

  // A new result is only loaded from the completion step.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_DONE))
    else $error("result produced outside completion step");

  // An accepted item always starts the sequencer.
  a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted item did not start execution");

  // A found flag comes only with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[STATUS_W + DATA_W]) |-> (out_data_r[STATUS_W-1:0] == ST_OK))
    else $error("found flag with failing status");

endmodule

// ===== dv/tb_bounded_deque_search_remove.sv =====
// Self-checking testbench for the bounded deque with search and remove-first-match.
`timescale 1ns / 100ps

module tb_bounded_deque_search_remove;
  import bdsr_pkg::*;

  localparam int DEPTH = 16;
  // Codes the block does not define; it must ignore them and report the length.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 850;
  // Slowest item is a remove on a full list, so the quiet spell at the end
  // covers that with margin.
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;
  // Per item at worst: the full remove, the longest sender gap and the longest
  // receiver stall; 900 items of that, taken four times over.
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] val;
  } cmd_item_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] popped;
    logic              found;
    logic [LEN_W-1:0]  length;
  } deque_result_t;

  // Shapes of the random stimulus: each segment leans towards one kind of work.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_SEEK, MIX_NOISE} mix_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // Fields from bit 0: command[2:0], value[34:3], zero padding[39:35].
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // Fields from bit 0: status[1:0], popped_value[33:2], found[34], length[39:35].
  logic [OUT_TDATA_W-1:0] out_tdata;

  bounded_deque_search_remove #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  cmd_item_t     pending_cmds[$];
  cmd_item_t     on_bus;
  deque_result_t expected_results[$];

  // Shadow copy of the list: circular store, front position and entry count.
  logic [DATA_W-1:0] dq_store [DEPTH];
  int dq_front = 0;
  int dq_count = 0;

  int n_items = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_hits = 0;
  int n_misses = 0;
  int cycles = 0;

  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  // Works out the result of one command and updates the shadow list, exactly
  // as the block must: front pushes step the front position back, removes
  // close the gap by moving every later entry one place forward.
  function automatic deque_result_t apply_command(logic [CMD_W-1:0] op,
                                                  logic [DATA_W-1:0] val);
    deque_result_t r;
    int pos;
    int k;
    r.status = ST_OK;
    r.popped = '0;
    r.found  = 1'b0;
    pos = -1;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else if (op == CMD_PUSH_FRONT) begin
          dq_front = (dq_front + DEPTH - 1) % DEPTH;
          dq_store[dq_front] = val;
          dq_count++;
        end else begin
          dq_store[(dq_front + dq_count) % DEPTH] = val;
          dq_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else if (op == CMD_POP_FRONT) begin
          r.popped = dq_store[dq_front];
          dq_front = (dq_front + 1) % DEPTH;
          dq_count--;
        end else begin
          r.popped = dq_store[(dq_front + dq_count - 1) % DEPTH];
          dq_count--;
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        for (k = 0; k < dq_count; k++) begin
          if (pos < 0 && dq_store[(dq_front + k) % DEPTH] == val) pos = k;
        end
        if (pos < 0) begin
          r.status = ST_MISS;
          n_misses++;
        end else begin
          r.found = 1'b1;
          n_hits++;
          if (op == CMD_REMOVE) begin
            for (k = pos; k + 1 < dq_count; k++) begin
              dq_store[(dq_front + k) % DEPTH] = dq_store[(dq_front + k + 1) % DEPTH];
            end
            dq_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.length = LEN_W'(dq_count);
    return r;
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] op, logic [DATA_W-1:0] val);
    cmd_item_t it;
    it.op  = op;
    it.val = val;
    pending_cmds.push_back(it);
    n_items++;
  endtask

  // Driver: presents queued items in bursts with random gaps between them.
  // The presented item is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_command(on_bus.op, on_bus.val));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          on_bus = pending_cmds.pop_front();
          in_tdata <= {{(IN_TDATA_W - DATA_W - CMD_W){1'b0}}, on_bus.val, on_bus.op};
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            // About a quarter of the bursts run straight on with no gap.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver switches between always ready, random stalls and
  // mostly stalled, and every accepted result is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    deque_result_t want;
    logic [STATUS_W-1:0] got_status;
    logic [DATA_W-1:0]   got_popped;
    logic                got_found;
    logic [LEN_W-1:0]    got_length;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[1:0];
        got_popped = out_tdata[33:2];
        got_found  = out_tdata[34];
        got_length = out_tdata[39:35];
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting: tdata %h", out_tdata);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            n_errors++;
          end
          if (got_popped !== want.popped) begin
            $error("popped_value: expected %h, got %h", want.popped, got_popped);
            n_errors++;
          end
          if (got_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got_found);
            n_errors++;
          end
          if (got_length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got_length);
            n_errors++;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [DATA_W-1:0] pool [6];
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] val;
    mix_t mix;
    int useful;
    int seg_left;
    int roll;
    int i;

    // Directed part: an empty list first, so refused pops and misses on
    // nothing, plus the two spare command codes.
    queue_cmd(CMD_POP_FRONT, $urandom);
    queue_cmd(CMD_POP_BACK, $urandom);
    queue_cmd(CMD_SEARCH, 32'h0000_0000);
    queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF);
    queue_cmd(CMD_SPARE_6, $urandom);
    queue_cmd(CMD_SPARE_7, $urandom);
    // Fill to the brim from both ends, with the value extremes first and a
    // repeated value scattered about so that a remove must pick the first one.
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = (i % 3 == 0) ? 32'h0000_0005 : $urandom;
      endcase
      queue_cmd((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, val);
    end
    // Pushes into a full list are refused; then hits, misses and a remove
    // from the middle, and a pop from each end.
    queue_cmd(CMD_PUSH_FRONT, 32'h1111_1111);
    queue_cmd(CMD_PUSH_BACK, 32'h2222_2222);
    queue_cmd(CMD_SEARCH, 32'h0000_0005);
    queue_cmd(CMD_SEARCH, 32'h1234_5678);
    queue_cmd(CMD_REMOVE, 32'h0000_0005);
    queue_cmd(CMD_REMOVE, 32'h1234_5678);
    queue_cmd(CMD_POP_FRONT, $urandom);
    queue_cmd(CMD_POP_BACK, $urandom);

    // Random part, in segments. Values mostly come from a small pool that is
    // refreshed per segment, so searches and removes hit and duplicates occur.
    useful = 0;
    seg_left = 0;
    mix = MIX_NOISE;
    while (useful < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        roll = $urandom_range(0, 9);
        mix = (roll < 3) ? MIX_FILL : (roll < 6) ? MIX_DRAIN : (roll < 9) ? MIX_SEEK : MIX_NOISE;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        for (i = 2; i < 6; i++) pool[i] = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 7);
      end
      seg_left--;
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  op = (roll < 70) ? CMD_W'(CMD_PUSH_FRONT + $urandom_range(0, 1))
                      : (roll < 85) ? CMD_W'(CMD_SEARCH + $urandom_range(0, 1))
                      : CMD_W'(CMD_POP_FRONT + $urandom_range(0, 1));
        MIX_DRAIN: op = (roll < 70) ? CMD_W'(CMD_POP_FRONT + $urandom_range(0, 1))
                      : (roll < 85) ? CMD_REMOVE
                      : CMD_W'(CMD_PUSH_FRONT + $urandom_range(0, 1));
        MIX_SEEK:  op = (roll < 60) ? CMD_W'(CMD_SEARCH + $urandom_range(0, 1))
                      : CMD_W'(CMD_PUSH_FRONT + $urandom_range(0, 3));
        default:   op = CMD_W'($urandom_range(0, 7));
      endcase
      val = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 5)] : $urandom;
      queue_cmd(op, val);
      if (op != CMD_SPARE_6 && op != CMD_SPARE_7) useful++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_accepted == n_items);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d command items and checked %0d results in %0d cycles",
             n_items, n_checked, cycles);
    $display("refused pushes %0d, refused pops %0d, search/remove hits %0d, misses %0d",
             n_full, n_empty, n_hits, n_misses);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdsr_pkg.sv
rtl/bdsr_store.sv
rtl/bounded_deque_search_remove.sv
dv/tb_bounded_deque_search_remove.sv
